### rtl/core/psg_pkg.sv
// Shared types, constants and level table for the three-voice sound generator.
package psg_pkg;

  localparam logic [3:0]  REG_NOISE_PER  = 4'd6;
  localparam logic [3:0]  REG_MIXER      = 4'd7;
  localparam logic [1:0]  REG_VOL_HI     = 2'b10;   // volume registers 8..10
  localparam logic [3:0]  REG_ENV_FINE   = 4'd11;
  localparam logic [3:0]  REG_ENV_COARSE = 4'd12;
  localparam logic [3:0]  REG_ENV_SHAPE  = 4'd13;
  localparam logic [7:0]  MIXER_RESET    = 8'h3F;

  localparam logic [17:0] RATE_RESET     = 18'd44100;
  localparam logic [21:0] CLOCK_RESET    = 22'd1789772;
  localparam logic [16:0] NOISE_SEED     = 17'h1FFFF;
  localparam logic signed [13:0] BLOCK_COEF = 14'sd8110;

  typedef enum logic [1:0] {
    KIND_SELECT, KIND_WRITE, KIND_READ, KIND_RENDER
  } psg_kind_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_READ, S_RC_LO, S_RC_HI, S_RC_START, S_RC_WAIT,
    S_R_MIXER, S_R_ISSUE, S_R_USE, S_B_MUL, S_B_SUM, S_DONE
  } psg_state_t;

  typedef enum logic [1:0] {
    DIV_IDLE, DIV_MUL, DIV_CHECK, DIV_RUN
  } psg_div_state_t;

  typedef struct packed {
    logic        start;
    logic        env;      // envelope divider (256) instead of 16
    logic [15:0] period;
  } psg_div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] value;
  } psg_div_rsp_t;

  function automatic logic [13:0] level(input logic [3:0] idx);
    logic [13:0] v;
    case (idx)
      4'd0:    v = 14'd0;
      4'd1:    v = 14'd64;
      4'd2:    v = 14'd90;
      4'd3:    v = 14'd128;
      4'd4:    v = 14'd181;
      4'd5:    v = 14'd256;
      4'd6:    v = 14'd362;
      4'd7:    v = 14'd512;
      4'd8:    v = 14'd724;
      4'd9:    v = 14'd1024;
      4'd10:   v = 14'd1448;
      4'd11:   v = 14'd2048;
      4'd12:   v = 14'd2896;
      4'd13:   v = 14'd4096;
      4'd14:   v = 14'd5792;
      default: v = 14'd8192;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/psg_in_if.sv
// Request channel: bus access kind and data byte.
interface psg_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] bus_value;
  modport source (output valid, kind, bus_value, input ready);
  modport sink (input valid, kind, bus_value, output ready);
endinterface

### rtl/core/psg_out_if.sv
// Response channel: register read data and audio sample.
interface psg_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         read_value;
  logic signed [15:0] audio_sample;
  modport source (output valid, read_value, audio_sample, input ready);
  modport sink (input valid, read_value, audio_sample, output ready);
endinterface

### rtl/core/psg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module psg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/psg_incr_div.sv
// Phase increment unit: (clock << 32) / (divider * period * rate), one quotient bit per cycle.
module psg_incr_div (
  input  logic                 clk,
  input  logic                 rst,
  input  psg_pkg::psg_div_req_t req,
  input  logic [17:0]          rate,
  input  logic [21:0]          clock,
  output psg_pkg::psg_div_rsp_t rsp
);
  psg_pkg::psg_div_state_t state;
  logic        env;
  logic [15:0] period;
  logic [33:0] prod;
  logic [41:0] den;
  logic [41:0] rem;
  logic [31:0] quo;
  logic [4:0]  cnt;
  logic        done;
  logic [41:0] den_shift;
  logic [42:0] rem2;
  logic        fit;

  assign den_shift = env ? {prod, 8'd0} : {4'd0, prod, 4'd0};
  assign rem2      = {rem, 1'b0};
  assign fit       = rem2 >= {1'b0, den};
  assign rsp.done  = done;
  assign rsp.value = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psg_pkg::DIV_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        psg_pkg::DIV_IDLE: begin
          if (req.start) begin
            env    <= req.env;
            period <= (req.period == 16'd0) ? 16'd1 : req.period;
            state  <= psg_pkg::DIV_MUL;
          end
        end
        psg_pkg::DIV_MUL: begin
          prod  <= {18'd0, period} * {16'd0, rate};
          state <= psg_pkg::DIV_CHECK;
        end
        psg_pkg::DIV_CHECK: begin
          den <= den_shift;
          rem <= {20'd0, clock};
          cnt <= 5'd31;
          if (den_shift == 42'd0) begin
            quo   <= 32'd0;
            done  <= 1'b1;
            state <= psg_pkg::DIV_IDLE;
          end else if ({20'd0, clock} >= den_shift) begin
            // quotient would not fit: saturate
            quo   <= '1;
            done  <= 1'b1;
            state <= psg_pkg::DIV_IDLE;
          end else begin
            quo   <= 32'd0;
            state <= psg_pkg::DIV_RUN;
          end
        end
        psg_pkg::DIV_RUN: begin
          rem <= fit ? 42'(rem2 - {1'b0, den}) : rem2[41:0];
          quo <= {quo[30:0], fit};
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            done  <= 1'b1;
            state <= psg_pkg::DIV_IDLE;
          end
        end
        default: state <= psg_pkg::DIV_IDLE;
      endcase
    end
  end
endmodule

### rtl/core/psg_three_voice_sound_generator.sv
// Top level of the three-voice sound generator: control sequencer, state memories, mixer.
// Usage:
//  - req carries bus transactions: select register, write data, read data, render.
//    Every transaction yields exactly one rsp transaction; read_value is nonzero only
//    for reads, audio_sample only for renders.
//  - APB port: sample_rate at 0x0, chip_clock_hz at 0x4, pready tied high. A write
//    recomputes all phase increments; req.ready stays low until that is done.
//  - Register file, phases and increments live in three small RAMs (registered read).
//  - Render: one read/modify/write pass per phase entry, then the DC blocker multiply.
//  - A write to a tone, noise or envelope period register, and any config write,
//    runs the increment unit once per entry, through the bit-serial 32-step divider.
//  - One transaction is worked on at a time; req.ready is high only when idle.
//    A finished result sits in the output register, so the next request can be
//    taken while the receiver stalls; processing then waits in DONE for the slot.
//  - Reset: registers read as zero except the mixer (0x3F), phases read as zero
//    through valid bits, and the increments are computed once before req.ready
//    first rises (same length as a config recompute).
module psg_three_voice_sound_generator #(
  parameter int VOICES = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  psg_in_if.sink      req,
  psg_out_if.source   rsp
);
  localparam int ENTRIES = VOICES + 2;
  localparam int EW = $clog2(ENTRIES);
  localparam logic [EW-1:0] NOISE_IDX = EW'(VOICES);
  localparam logic [EW-1:0] ENV_IDX = EW'(VOICES + 1);
  localparam int MW = $clog2(VOICES + 1) + 15;

  // ---------------- configuration ----------------
  logic [17:0] sample_rate;
  logic [21:0] chip_clock;
  logic        cfg_pend;
  logic        cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {10'd0, chip_clock} : {14'd0, sample_rate};

  // ---------------- sequencer state ----------------
  psg_pkg::psg_state_t state, state_next;
  psg_pkg::psg_kind_t  it_kind;
  logic [7:0]  it_bus;
  logic [3:0]  sel_idx;
  logic        item_active;
  logic [EW-1:0] ent;
  logic [1:0]  vc;          // voice index modulo three
  logic        ent_last;

  // register file RAM
  logic        reg_we;
  logic [3:0]  reg_raddr;
  logic [7:0]  reg_q;
  logic [15:0] reg_valid;
  logic        reg_vq;
  logic [3:0]  reg_aq;
  logic [7:0]  reg_val;
  logic [7:0]  per_lo;

  // phase and increment RAMs
  logic            ph_we;
  logic [EW-1:0]   ph_waddr;
  logic [31:0]     ph_wdata;
  logic [31:0]     ph_q;
  logic [ENTRIES-1:0] ph_valid;
  logic            ph_vq;
  logic [31:0]     ph_val;
  logic            inc_we;
  logic [31:0]     inc_q;
  logic [32:0]     ph_sum;

  psg_pkg::psg_div_req_t div_req;
  psg_pkg::psg_div_rsp_t div_rsp;
  logic        div_start;
  logic        is_tone;
  logic        is_noise;

  // sound state
  logic [16:0] noise_shifter;
  logic        noise_fb;
  logic [16:0] noise_next;
  logic [3:0]  env_shape;
  logic [3:0]  env_level;
  logic        env_rising;
  logic        env_stopped;
  logic        env_rise_next;
  logic [7:0]  mixer;
  logic signed [MW-1:0] mix;
  logic signed [MW-1:0] mix_adj;
  logic signed [MW-1:0] half;
  logic [31:0] blk_in;
  logic [31:0] blk_out;
  logic signed [45:0] blk_prod;
  logic [31:0] half32;
  logic [31:0] blk_y;
  logic [15:0] clamped;
  logic [4:0]  vol;
  logic [13:0] amp;
  logic        gate;

  // result staging and output register
  logic [7:0]  res_read;
  logic [15:0] res_sample;
  logic        out_valid;
  logic [7:0]  out_read;
  logic [15:0] out_sample;
  logic        out_load;

  assign reg_val  = reg_vq ? reg_q :
                    ((reg_aq == psg_pkg::REG_MIXER) ? psg_pkg::MIXER_RESET : 8'd0);
  assign ph_val   = ph_vq ? ph_q : 32'd0;
  assign ph_sum   = {1'b0, ph_val} + {1'b0, inc_q};
  assign ent_last = (ent == ENV_IDX);
  assign is_tone  = (ent < NOISE_IDX);
  assign is_noise = (ent == NOISE_IDX);

  assign noise_fb   = noise_shifter[0] ^ noise_shifter[3];
  assign noise_next = {noise_fb, noise_shifter[16:1]};
  assign env_rise_next = env_rising ^ env_shape[1];

  assign vol  = reg_val[4:0];
  assign amp  = psg_pkg::level(vol[4] ? env_level : vol[3:0]);
  assign gate = (mixer[{1'b0, vc}] || ph_sum[31]) &&
                (mixer[3'({1'b0, vc}) + 3'd3] || noise_shifter[0]);

  assign mix_adj = mix + $signed({{(MW-1){1'b0}}, mix[MW-1]});
  assign half    = mix_adj >>> 1;
  assign half32  = {{(32-MW){half[MW-1]}}, half};
  assign blk_y   = half32 - blk_in + blk_prod[44:13];
  assign clamped = ($signed(blk_y) > 32'sd32767)  ? 16'h7FFF :
                   ($signed(blk_y) < -32'sd32768) ? 16'h8000 : blk_y[15:0];

  assign out_load = (state == psg_pkg::S_DONE) && (!out_valid || rsp.ready);

  assign div_req.start  = div_start;
  assign div_req.env    = ent_last;
  assign div_req.period = is_tone  ? {4'd0, reg_val[3:0], per_lo} :
                          is_noise ? {11'd0, per_lo[4:0]} : {reg_val, per_lo};

  assign ph_waddr = (state == psg_pkg::S_EXEC) ? ENV_IDX : ent;
  assign ph_wdata = (state == psg_pkg::S_EXEC) ? 32'd0 : ph_sum[31:0];

  psg_ram #(.WIDTH(8), .DEPTH(16)) u_reg_ram (
    .clk(clk), .we(reg_we), .waddr(sel_idx), .wdata(it_bus),
    .raddr(reg_raddr), .rdata(reg_q)
  );

  psg_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_phase_ram (
    .clk(clk), .we(ph_we), .waddr(ph_waddr), .wdata(ph_wdata),
    .raddr(ent), .rdata(ph_q)
  );

  psg_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_incr_ram (
    .clk(clk), .we(inc_we), .waddr(ent), .wdata(div_rsp.value),
    .raddr(ent), .rdata(inc_q)
  );

  psg_incr_div u_div (
    .clk(clk), .rst(rst), .req(div_req), .rate(sample_rate),
    .clock(chip_clock), .rsp(div_rsp)
  );

  // ---------------- state register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psg_pkg::S_RC_LO;   // compute increments after reset
    end else begin
      state <= state_next;
    end
  end

  // ---------------- next state and strobes ----------------
  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    reg_raddr  = sel_idx;
    reg_we     = 1'b0;
    ph_we      = 1'b0;
    inc_we     = 1'b0;
    div_start  = 1'b0;
    case (state)
      psg_pkg::S_IDLE: begin
        req.ready = !cfg_pend;
        if (cfg_pend) begin
          state_next = psg_pkg::S_RC_LO;
        end else if (req.valid) begin
          state_next = psg_pkg::S_EXEC;
        end
      end
      psg_pkg::S_EXEC: begin
        case (it_kind)
          psg_pkg::KIND_SELECT: state_next = psg_pkg::S_DONE;
          psg_pkg::KIND_WRITE: begin
            reg_we = 1'b1;
            ph_we  = (sel_idx == psg_pkg::REG_ENV_SHAPE);
            if (sel_idx <= psg_pkg::REG_NOISE_PER || sel_idx == psg_pkg::REG_ENV_FINE ||
                sel_idx == psg_pkg::REG_ENV_COARSE) begin
              state_next = psg_pkg::S_RC_LO;
            end else begin
              state_next = psg_pkg::S_DONE;
            end
          end
          psg_pkg::KIND_READ: state_next = psg_pkg::S_READ;
          psg_pkg::KIND_RENDER: begin
            reg_raddr  = psg_pkg::REG_MIXER;
            state_next = psg_pkg::S_R_MIXER;
          end
          default: state_next = psg_pkg::S_DONE;
        endcase
      end
      psg_pkg::S_READ: state_next = psg_pkg::S_DONE;
      psg_pkg::S_RC_LO: begin
        reg_raddr  = is_tone ? {1'b0, vc, 1'b0} :
                     is_noise ? psg_pkg::REG_NOISE_PER : psg_pkg::REG_ENV_FINE;
        state_next = psg_pkg::S_RC_HI;
      end
      psg_pkg::S_RC_HI: begin
        reg_raddr  = is_tone ? {1'b0, vc, 1'b1} : psg_pkg::REG_ENV_COARSE;
        state_next = psg_pkg::S_RC_START;
      end
      psg_pkg::S_RC_START: begin
        div_start  = 1'b1;
        state_next = psg_pkg::S_RC_WAIT;
      end
      psg_pkg::S_RC_WAIT: begin
        if (div_rsp.done) begin
          inc_we = 1'b1;
          if (ent_last) begin
            state_next = item_active ? psg_pkg::S_DONE : psg_pkg::S_IDLE;
          end else begin
            state_next = psg_pkg::S_RC_LO;
          end
        end
      end
      psg_pkg::S_R_MIXER: state_next = psg_pkg::S_R_ISSUE;
      psg_pkg::S_R_ISSUE: begin
        reg_raddr  = {psg_pkg::REG_VOL_HI, vc};
        state_next = psg_pkg::S_R_USE;
      end
      psg_pkg::S_R_USE: begin
        ph_we      = 1'b1;
        state_next = ent_last ? psg_pkg::S_B_MUL : psg_pkg::S_R_ISSUE;
      end
      psg_pkg::S_B_MUL: state_next = psg_pkg::S_B_SUM;
      psg_pkg::S_B_SUM: state_next = psg_pkg::S_DONE;
      psg_pkg::S_DONE: begin
        if (out_load) begin
          state_next = psg_pkg::S_IDLE;
        end
      end
      default: state_next = psg_pkg::S_IDLE;
    endcase
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    reg_vq <= reg_valid[reg_raddr];
    reg_aq <= reg_raddr;
    ph_vq  <= ph_valid[ent];
    if (rst) begin
      sample_rate   <= psg_pkg::RATE_RESET;
      chip_clock    <= psg_pkg::CLOCK_RESET;
      cfg_pend      <= 1'b0;
      sel_idx       <= 4'd0;
      item_active   <= 1'b0;
      ent           <= '0;
      vc            <= 2'd0;
      reg_valid     <= '0;
      ph_valid      <= '0;
      noise_shifter <= psg_pkg::NOISE_SEED;
      env_shape     <= 4'd0;
      env_level     <= 4'hF;
      env_rising    <= 1'b0;
      env_stopped   <= 1'b0;
      blk_in        <= 32'd0;
      blk_out       <= 32'd0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2]) begin
          chip_clock <= pwdata[21:0];
        end else begin
          sample_rate <= pwdata[17:0];
        end
        cfg_pend <= 1'b1;
      end else if (state == psg_pkg::S_IDLE) begin
        cfg_pend <= 1'b0;
      end

      if (req.valid && req.ready) begin
        it_kind     <= psg_pkg::psg_kind_t'(req.kind);
        it_bus      <= req.bus_value;
        item_active <= 1'b1;
      end

      if (reg_we) begin
        reg_valid[sel_idx] <= 1'b1;
      end
      if (ph_we) begin
        ph_valid[ph_waddr] <= 1'b1;
      end

      // step through phase entries; vc follows ent modulo three
      if ((state == psg_pkg::S_RC_WAIT && div_rsp.done) || state == psg_pkg::S_R_USE) begin
        if (ent_last) begin
          ent <= '0;
          vc  <= 2'd0;
        end else begin
          ent <= ent + 1'b1;
          vc  <= (vc == 2'd2) ? 2'd0 : vc + 2'd1;
        end
      end

      case (state)
        psg_pkg::S_EXEC: begin
          res_read   <= 8'd0;
          res_sample <= 16'd0;
          mix        <= '0;
          if (it_kind == psg_pkg::KIND_SELECT) begin
            sel_idx <= it_bus[3:0];
          end
          if (it_kind == psg_pkg::KIND_WRITE && sel_idx == psg_pkg::REG_ENV_SHAPE) begin
            // envelope restart; its phase is cleared through the phase RAM
            env_shape   <= it_bus[3:0];
            env_stopped <= 1'b0;
            env_rising  <= it_bus[2];
            env_level   <= it_bus[2] ? 4'h0 : 4'hF;
          end
        end
        psg_pkg::S_READ: res_read <= reg_val;
        psg_pkg::S_RC_HI: per_lo <= reg_val;
        psg_pkg::S_R_MIXER: mixer <= reg_val;
        psg_pkg::S_R_USE: begin
          if (is_tone) begin
            mix <= gate ? mix + $signed({{(MW-14){1'b0}}, amp})
                        : mix - $signed({{(MW-14){1'b0}}, amp});
          end else if (is_noise) begin
            if (ph_sum[32]) begin
              noise_shifter <= (noise_next == 17'd0) ? psg_pkg::NOISE_SEED : noise_next;
            end
          end else if (ph_sum[32] && !env_stopped) begin
            if (env_rising && env_level != 4'hF) begin
              env_level <= env_level + 4'd1;
            end else if (!env_rising && env_level != 4'h0) begin
              env_level <= env_level - 4'd1;
            end else if (!env_shape[3]) begin
              env_level   <= 4'h0;
              env_stopped <= 1'b1;
            end else begin
              env_rising <= env_rise_next;
              if (env_shape[0]) begin
                env_level   <= env_rise_next ? 4'hF : 4'h0;
                env_stopped <= 1'b1;
              end else begin
                env_level <= env_rise_next ? 4'h0 : 4'hF;
              end
            end
          end
        end
        psg_pkg::S_B_MUL: blk_prod <= $signed(blk_out) * psg_pkg::BLOCK_COEF;
        psg_pkg::S_B_SUM: begin
          blk_in     <= half32;
          blk_out    <= blk_y;
          res_sample <= clamped;
        end
        default: ;
      endcase

      if (out_load) begin
        out_valid   <= 1'b1;
        out_read    <= res_read;
        out_sample  <= res_sample;
        item_active <= 1'b0;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.read_value   = out_read;
  assign rsp.audio_sample = out_sample;

  // ---------------- assertions ----------------
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> state == psg_pkg::S_EXEC)
    else $error("accepted transaction not executed");

  a_noise_nonzero: assert property (@(posedge clk) disable iff (rst)
    noise_shifter != 17'd0)
    else $error("noise shifter locked at zero");

  a_env_hold: assert property (@(posedge clk) disable iff (rst)
    env_stopped |-> (env_level == 4'h0 || env_level == 4'hF))
    else $error("stopped envelope at intermediate level");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == psg_pkg::S_RC_WAIT)
    else $error("increment result with no recompute pending");

endmodule
